### rtl/core/dtsc_pkg.sv
// ----------------------------------------------------------------------------
// dtsc_pkg: shared types and constants for the date-time string checker
// Item structs, error codes, position classes and decimal helpers.
// ----------------------------------------------------------------------------
package dtsc_pkg;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // string positions are 1-based; the counter saturates one past the end
  localparam logic [4:0] POS_FIRST = 5'd1;
  localparam logic [4:0] POS_MIN   = 5'd19;
  localparam logic [4:0] POS_MAX   = 5'd21;
  localparam logic [4:0] POS_SAT   = 5'd22;

  // record queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FORMAT = 2'd1,
    ERR_DATE   = 2'd2,
    ERR_TIME   = 2'd3
  } err_code_t;

  typedef enum logic [3:0] {
    PK_DOT,
    PK_COMMA,
    PK_COLON,
    PK_ANY,
    PK_DAY,
    PK_MONTH,
    PK_YEAR_HI,
    PK_YEAR_LO,
    PK_HOUR,
    PK_MINUTE,
    PK_SECOND,
    PK_BAD
  } pos_kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  error_code;
    logic [6:0]  day_out;
    logic [6:0]  month_out;
    logic [13:0] year_out;
    logic [6:0]  hour_out;
    logic [6:0]  minute_out;
    logic [6:0]  second_out;
  } out_item_t;

  // parsed string handed from front to back
  typedef struct packed {
    logic        fmt_ok;
    logic        leap;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic pos_kind_t pos_kind(input logic [4:0] pos);
    pos_kind_t k;
    unique case (pos)
      5'd3, 5'd6:   k = PK_DOT;
      5'd11:        k = PK_COMMA;
      5'd14, 5'd17: k = PK_COLON;
      5'd20, 5'd21: k = PK_ANY;
      5'd1, 5'd2:   k = PK_DAY;
      5'd4, 5'd5:   k = PK_MONTH;
      5'd7, 5'd8:   k = PK_YEAR_HI;
      5'd9, 5'd10:  k = PK_YEAR_LO;
      5'd12, 5'd13: k = PK_HOUR;
      5'd15, 5'd16: k = PK_MINUTE;
      5'd18, 5'd19: k = PK_SECOND;
      default:      k = PK_BAD;
    endcase
    return k;
  endfunction

  // acc * 10 + d, wrapped to the accumulator width
  function automatic logic [6:0] push_dec7(input logic [6:0] acc, input logic [3:0] d);
    logic [9:0] s;
    s = {acc, 3'b000} + {2'b00, acc, 1'b0} + {6'b0, d};
    return s[6:0];
  endfunction

  function automatic logic [13:0] push_dec14(input logic [13:0] acc, input logic [3:0] d);
    logic [16:0] s;
    s = {acc, 3'b000} + {2'b00, acc, 1'b0} + {13'b0, d};
    return s[13:0];
  endfunction

endpackage

### rtl/core/dtsc_front.sv
// ----------------------------------------------------------------------------
// dtsc_front: character parser
// Checks each character against its position, accumulates the decimal
// fields and pushes one record into the queue on the final character.
// ----------------------------------------------------------------------------
module dtsc_front import dtsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  q_status_t q_stat,
  output logic      q_push,
  output rec_t      q_wdata
);

  logic [4:0]  pos_r, pos_nxt;
  logic        fmt_ok_r, fmt_ok_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  yhi_r, yhi_nxt;   // first two year digits
  logic [6:0]  ylo_r, ylo_nxt;   // last two year digits
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;

  logic        accept;
  logic        is_digit;
  logic [7:0]  char_off;
  logic [3:0]  digit;
  logic        len_ok;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && in_data.last_char;

  assign is_digit = (in_data.char_in >= CHAR_ZERO) && (in_data.char_in <= CHAR_NINE);
  assign char_off = in_data.char_in - CHAR_ZERO;
  assign digit    = char_off[3:0];

  always_comb begin
    fmt_ok_nxt = fmt_ok_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    yhi_nxt    = yhi_r;
    ylo_nxt    = ylo_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    unique case (pos_kind(pos_r))
      PK_DOT:   if (in_data.char_in != CHAR_DOT) fmt_ok_nxt = 1'b0;
      PK_COMMA: if (in_data.char_in != CHAR_COMMA) fmt_ok_nxt = 1'b0;
      PK_COLON: if (in_data.char_in != CHAR_COLON) fmt_ok_nxt = 1'b0;
      PK_ANY:   ;
      PK_DAY: begin
        if (!is_digit) fmt_ok_nxt = 1'b0;
        else day_nxt = push_dec7(day_r, digit);
      end
      PK_MONTH: begin
        if (!is_digit) fmt_ok_nxt = 1'b0;
        else month_nxt = push_dec7(month_r, digit);
      end
      PK_YEAR_HI: begin
        if (!is_digit) fmt_ok_nxt = 1'b0;
        else begin
          year_nxt = push_dec14(year_r, digit);
          yhi_nxt  = push_dec7(yhi_r, digit);
        end
      end
      PK_YEAR_LO: begin
        if (!is_digit) fmt_ok_nxt = 1'b0;
        else begin
          year_nxt = push_dec14(year_r, digit);
          ylo_nxt  = push_dec7(ylo_r, digit);
        end
      end
      PK_HOUR: begin
        if (!is_digit) fmt_ok_nxt = 1'b0;
        else hour_nxt = push_dec7(hour_r, digit);
      end
      PK_MINUTE: begin
        if (!is_digit) fmt_ok_nxt = 1'b0;
        else minute_nxt = push_dec7(minute_r, digit);
      end
      PK_SECOND: begin
        if (!is_digit) fmt_ok_nxt = 1'b0;
        else second_nxt = push_dec7(second_r, digit);
      end
      PK_BAD:   fmt_ok_nxt = 1'b0;
      default:  fmt_ok_nxt = 1'b0;
    endcase
    pos_nxt = (pos_r < POS_SAT) ? pos_r + 5'd1 : pos_r;
  end

  assign len_ok = (pos_r >= POS_MIN) && (pos_r <= POS_MAX);

  // leap rule from the digit pairs: n mod 4 of a two-digit pair is its low bits
  always_comb begin
    q_wdata.fmt_ok = fmt_ok_nxt && len_ok;
    q_wdata.leap   = (ylo_nxt == 7'd0) ? (yhi_nxt[1:0] == 2'b00) : (ylo_nxt[1:0] == 2'b00);
    q_wdata.day    = day_nxt;
    q_wdata.month  = month_nxt;
    q_wdata.year   = year_nxt;
    q_wdata.hour   = hour_nxt;
    q_wdata.minute = minute_nxt;
    q_wdata.second = second_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      pos_r    <= POS_FIRST;
      fmt_ok_r <= 1'b1;
      day_r    <= '0;
      month_r  <= '0;
      year_r   <= '0;
      yhi_r    <= '0;
      ylo_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      fmt_ok_r <= fmt_ok_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      yhi_r    <= yhi_nxt;
      ylo_r    <= ylo_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != 5'd0) && (pos_r <= POS_SAT))
    else $error("position counter out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (pos_r == POS_FIRST) && fmt_ok_r)
    else $error("parser not cleared after final character");
`endif

endmodule

### rtl/core/dtsc_queue.sv
// ----------------------------------------------------------------------------
// dtsc_queue: record queue
// Small first-in first-out buffer of parsed records between front and back.
// ----------------------------------------------------------------------------
module dtsc_queue import dtsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_push,
  input  rec_t      q_wdata,
  input  logic      q_pop,
  output rec_t      q_rdata,
  output q_status_t q_stat
);

  rec_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_rdata      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!q_push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) wr_ptr_r <= QAW'(wr_ptr_r + 1'b1);
      if (q_pop)  rd_ptr_r <= QAW'(rd_ptr_r + 1'b1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) mem_r[wr_ptr_r] <= q_wdata;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full && !q_pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty))
    else $error("pop from empty queue");
`endif

endmodule

### rtl/core/dtsc_back.sv
// ----------------------------------------------------------------------------
// dtsc_back: date and time validation
// Takes a parsed record, applies the calendar and clock range checks and
// holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module dtsc_back import dtsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_stat,
  input  rec_t      q_rdata,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;
  logic      load;
  logic [6:0] limit;
  logic      date_ok;
  logic      time_ok;
  err_code_t err;

  assign load  = !q_stat.empty && (!out_valid_r || !out_stall);
  assign q_pop = load;

  always_comb begin
    unique case (q_rdata.month)
      7'd4, 7'd6, 7'd9, 7'd11: limit = 7'd30;
      7'd2:                    limit = q_rdata.leap ? 7'd29 : 7'd28;
      default:                 limit = 7'd31;
    endcase
  end

  assign date_ok = (q_rdata.month != 7'd0) && (q_rdata.month <= 7'd12) &&
                   (q_rdata.day != 7'd0) && (q_rdata.day <= limit);
  assign time_ok = (q_rdata.hour <= 7'd23) && (q_rdata.minute <= 7'd59) &&
                   (q_rdata.second <= 7'd59);

  always_comb begin
    priority if (!q_rdata.fmt_ok) err = ERR_FORMAT;
    else if (!date_ok)            err = ERR_DATE;
    else if (!time_ok)            err = ERR_TIME;
    else                          err = ERR_NONE;
  end

  always_comb begin
    out_data_nxt.valid_res  = (err == ERR_NONE);
    out_data_nxt.error_code = err;
    if (err == ERR_FORMAT) begin
      out_data_nxt.day_out    = '0;
      out_data_nxt.month_out  = '0;
      out_data_nxt.year_out   = '0;
      out_data_nxt.hour_out   = '0;
      out_data_nxt.minute_out = '0;
      out_data_nxt.second_out = '0;
    end else begin
      out_data_nxt.day_out    = q_rdata.day;
      out_data_nxt.month_out  = q_rdata.month;
      out_data_nxt.year_out   = q_rdata.year;
      out_data_nxt.hour_out   = q_rdata.hour;
      out_data_nxt.minute_out = q_rdata.minute;
      out_data_nxt.second_out = q_rdata.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_valid_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.valid_res == (out_data_r.error_code == ERR_NONE)))
    else $error("valid flag disagrees with error code");

  a_format_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error_code == ERR_FORMAT) |->
      (out_data_r.day_out == '0) && (out_data_r.month_out == '0) &&
      (out_data_r.year_out == '0) && (out_data_r.hour_out == '0) &&
      (out_data_r.minute_out == '0) && (out_data_r.second_out == '0))
    else $error("format error with non-zero fields");

  a_pop_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped record not presented");
`endif

endmodule

### rtl/core/date_time_string_checker_top.sv
// ----------------------------------------------------------------------------
// date_time_string_checker_top: date-time command string checker
// Throughput: one character per cycle; strings may follow back to back.
// The result passes through the record queue and then the output register.
// Input stalls only when the two-entry record queue is full.
// Reset: synchronous, active low; clears parser, queue and output valid.
// ----------------------------------------------------------------------------
module date_time_string_checker_top import dtsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  q_status_t q_stat;
  logic      q_push;
  logic      q_pop;
  rec_t      q_wdata;
  rec_t      q_rdata;

  dtsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  dtsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  dtsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### verif/tb_date_time_string_checker_top.sv
// ----------------------------------------------------------------------------
// tb_date_time_string_checker_top: testbench for the date-time string checker
// Sends "DD.MM.YYYY,HH:MM:SS" strings one character at a time and parses
// them in parallel. Each result is checked field by field against the
// parsed verdict. Directed strings cover the calendar, time and format
// corners. Random traffic then runs under three idle patterns, and one
// long output hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_date_time_string_checker_top;
  import dtsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  date_time_string_checker_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser copy
  logic [4:0]  str_pos;
  logic        fmt_good;
  logic [6:0]  day_acc, month_acc, hour_acc, minute_acc, second_acc;
  logic [13:0] year_acc;
  out_item_t   verdict_q[$];

  logic [7:0]  txt[$];
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int mismatches = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int results_seen = 0;
  int input_held = 0;
  int err_seen[4] = '{0, 0, 0, 0};

  function automatic int month_len(input int m, input int y);
    bit leap;
    leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  task automatic clear_parse();
    str_pos    = POS_FIRST;
    fmt_good   = 1'b1;
    day_acc    = '0;
    month_acc  = '0;
    year_acc   = '0;
    hour_acc   = '0;
    minute_acc = '0;
    second_acc = '0;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    logic [4:0] p;
    logic       is_dig;
    logic [3:0] d;
    err_code_t  e;
    out_item_t  r;
    p = str_pos;
    is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d = is_dig ? 4'(c - CHAR_ZERO) : 4'd0;
    case (p)
      5'd3, 5'd6:   if (c != CHAR_DOT) fmt_good = 1'b0;
      5'd11:        if (c != CHAR_COMMA) fmt_good = 1'b0;
      5'd14, 5'd17: if (c != CHAR_COLON) fmt_good = 1'b0;
      5'd20, 5'd21: ;
      5'd1, 5'd2, 5'd4, 5'd5, 5'd7, 5'd8, 5'd9, 5'd10,
      5'd12, 5'd13, 5'd15, 5'd16, 5'd18, 5'd19: begin
        // a non-digit leaves the field untouched
        if (!is_dig) fmt_good = 1'b0;
        else if (p <= 5'd2)  day_acc    = day_acc * 7'd10 + 7'(d);
        else if (p <= 5'd5)  month_acc  = month_acc * 7'd10 + 7'(d);
        else if (p <= 5'd10) year_acc   = year_acc * 14'd10 + 14'(d);
        else if (p <= 5'd13) hour_acc   = hour_acc * 7'd10 + 7'(d);
        else if (p <= 5'd16) minute_acc = minute_acc * 7'd10 + 7'(d);
        else                 second_acc = second_acc * 7'd10 + 7'(d);
      end
      default: fmt_good = 1'b0;
    endcase
    if (str_pos < POS_SAT) str_pos = str_pos + 5'd1;
    if (last) begin
      if (!fmt_good || p < POS_MIN || p > POS_MAX)
        e = ERR_FORMAT;
      else if (month_acc == 0 || month_acc > 12 || day_acc == 0 ||
               day_acc > month_len(month_acc, year_acc))
        e = ERR_DATE;
      else if (hour_acc > 23 || minute_acc > 59 || second_acc > 59)
        e = ERR_TIME;
      else
        e = ERR_NONE;
      r = '0;
      r.valid_res  = (e == ERR_NONE);
      r.error_code = e;
      if (e != ERR_FORMAT) begin
        r.day_out    = day_acc;
        r.month_out  = month_acc;
        r.year_out   = year_acc;
        r.hour_out   = hour_acc;
        r.minute_out = minute_acc;
        r.second_out = second_acc;
      end
      verdict_q.push_back(r);
      clear_parse();
    end
  endtask

  // receiver: random stall, or a long hold-off when asked for one
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    logic      ok;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        ok = 1'b0;
        want = '0;
        if (mismatches < 10)
          $display("[%0d] result with nothing outstanding: err=%0d %0d.%0d.%0d %0d:%0d:%0d",
                   cycle_cnt, out_data.error_code, out_data.day_out, out_data.month_out,
                   out_data.year_out, out_data.hour_out, out_data.minute_out,
                   out_data.second_out);
      end else begin
        want = verdict_q.pop_front();
        results_seen++;
        err_seen[want.error_code]++;
        ok = (out_data.valid_res  === want.valid_res)  &&
             (out_data.error_code === want.error_code) &&
             (out_data.day_out    === want.day_out)    &&
             (out_data.month_out  === want.month_out)  &&
             (out_data.year_out   === want.year_out)   &&
             (out_data.hour_out   === want.hour_out)   &&
             (out_data.minute_out === want.minute_out) &&
             (out_data.second_out === want.second_out);
        if (!ok && mismatches < 10)
          $display("[%0d] mismatch: want v=%0b e=%0d %0d.%0d.%0d %0d:%0d:%0d, got v=%0b e=%0d %0d.%0d.%0d %0d:%0d:%0d",
                   cycle_cnt, want.valid_res, want.error_code, want.day_out,
                   want.month_out, want.year_out, want.hour_out, want.minute_out,
                   want.second_out, out_data.valid_res, out_data.error_code,
                   out_data.day_out, out_data.month_out, out_data.year_out,
                   out_data.hour_out, out_data.minute_out, out_data.second_out);
      end
      if (!ok) mismatches++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               verdict_q.size());
      $display("** date_time_string_checker_top: FAILED **");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    // one idle decision per cycle keeps the idle share at in_idle_pct
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: c, last_char: last};
    @(posedge clk);
    while (in_stall) begin
      input_held++;
      @(posedge clk);
    end
    parse_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < txt.size(); i++)
      send_char(txt[i], i == txt.size() - 1);
    strings_sent++;
  endtask

  task automatic put_num(input int v, input int ndig);
    int div;
    div = 1;
    for (int i = 1; i < ndig; i++) div = div * 10;
    for (int i = 0; i < ndig; i++) begin
      txt.push_back(CHAR_ZERO + 8'((v / div) % 10));
      div = div / 10;
    end
  endtask

  task automatic make_stamp(input int d, input int m, input int y,
                            input int h, input int mi, input int s);
    txt.delete();
    put_num(d, 2);  txt.push_back(CHAR_DOT);
    put_num(m, 2);  txt.push_back(CHAR_DOT);
    put_num(y, 4);  txt.push_back(CHAR_COMMA);
    put_num(h, 2);  txt.push_back(CHAR_COLON);
    put_num(mi, 2); txt.push_back(CHAR_COLON);
    put_num(s, 2);
  endtask

  task automatic send_stamp(input int d, input int m, input int y,
                            input int h, input int mi, input int s);
    make_stamp(d, m, y, h, mi, s);
    send_text();
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // plausible stamp with random content, biased towards the calendar edges
  task automatic make_plausible();
    int years[8] = '{0, 1900, 2000, 2023, 2024, 2100, 2400, 9999};
    int bad_mon[3] = '{0, 13, 99};
    int d, m, y, h, mi, s, len;
    y = ($urandom_range(1) == 0) ? $urandom_range(9999) : years[$urandom_range(7)];
    m = ($urandom_range(9) != 0) ? $urandom_range(1, 12) : bad_mon[$urandom_range(2)];
    len = (m >= 1 && m <= 12) ? month_len(m, y) : 31;
    case ($urandom_range(19))
      0:       d = 0;
      1:       d = $urandom_range(99);
      2, 3:    d = len + 1;
      4, 5:    d = len;
      default: d = $urandom_range(1, len);
    endcase
    h  = ($urandom_range(9) != 0) ? $urandom_range(23) : $urandom_range(24, 99);
    mi = ($urandom_range(9) != 0) ? $urandom_range(59) : $urandom_range(60, 99);
    s  = ($urandom_range(9) != 0) ? $urandom_range(59) : $urandom_range(60, 99);
    make_stamp(d, m, y, h, mi, s);
  endtask

  task automatic send_random_string();
    int k, n;
    k = $urandom_range(99);
    if (k < 60) begin
      make_plausible();
    end else if (k < 72) begin
      make_stamp($urandom_range(99), $urandom_range(99), $urandom_range(9999),
                 $urandom_range(99), $urandom_range(99), $urandom_range(99));
    end else if (k < 87) begin
      make_plausible();
      txt[$urandom_range(18)] = 8'($urandom_range(255));
    end else begin
      txt.delete();
      n = $urandom_range(1, 30);
      repeat (n) txt.push_back(8'($urandom_range(255)));
    end
    if (k < 87) begin
      // odd tails: any one or two characters, one short, or far too long
      case ($urandom_range(9))
        0, 1: txt.push_back(8'($urandom_range(255)));
        2:    repeat (2) txt.push_back(8'($urandom_range(255)));
        3:    void'(txt.pop_back());
        4:    repeat ($urandom_range(3, 11)) txt.push_back(8'($urandom_range(255)));
        default: ;
      endcase
    end
    send_text();
  endtask

  task automatic test_valid_strings();
    send_stamp(1, 1, 0, 0, 0, 0);
    send_stamp(31, 12, 9999, 23, 59, 59);
    send_stamp(29, 2, 2000, 12, 0, 0);
    send_stamp(30, 4, 1999, 7, 8, 9);
    make_stamp(29, 2, 2024, 12, 30, 45);
    txt.push_back(8'hFF);
    send_text();
    make_stamp(28, 2, 1900, 0, 0, 1);
    txt.push_back(8'h00);
    txt.push_back(8'h7A);
    send_text();
    wait_drain();
  endtask

  task automatic test_date_errors();
    send_stamp(29, 2, 1900, 0, 0, 0);
    send_stamp(29, 2, 2023, 0, 0, 0);
    send_stamp(0, 5, 2020, 0, 0, 0);
    send_stamp(15, 0, 2020, 0, 0, 0);
    send_stamp(15, 13, 2020, 0, 0, 0);
    send_stamp(31, 11, 2021, 0, 0, 0);
    send_stamp(32, 1, 2021, 0, 0, 0);
    // a bad date outranks a bad time
    send_stamp(99, 99, 9999, 99, 99, 99);
    wait_drain();
  endtask

  task automatic test_time_errors();
    send_stamp(1, 1, 2000, 24, 0, 0);
    send_stamp(1, 1, 2000, 23, 60, 0);
    send_stamp(1, 1, 2000, 23, 59, 60);
    send_stamp(1, 1, 2000, 99, 99, 99);
    wait_drain();
  endtask

  task automatic test_format_errors();
    make_stamp(1, 1, 2000, 0, 0, 0); txt[2]  = CHAR_COMMA; send_text();
    make_stamp(1, 1, 2000, 0, 0, 0); txt[5]  = CHAR_COLON; send_text();
    make_stamp(1, 1, 2000, 0, 0, 0); txt[10] = CHAR_DOT;   send_text();
    make_stamp(1, 1, 2000, 0, 0, 0); txt[13] = CHAR_ZERO;  send_text();
    make_stamp(1, 1, 2000, 0, 0, 0); txt[16] = CHAR_DOT;   send_text();
    // characters either side of the digit range
    make_stamp(1, 1, 2000, 0, 0, 0); txt[0]  = 8'h2F; send_text();
    make_stamp(1, 1, 2000, 0, 0, 0); txt[18] = 8'h3A; send_text();
    // a format fault outranks a bad date
    make_stamp(32, 13, 2000, 0, 0, 0); txt[7] = 8'hC1; send_text();
    wait_drain();
  endtask

  task automatic test_length_errors();
    txt.delete();
    txt.push_back(CHAR_ZERO);
    send_text();
    make_stamp(1, 1, 2000, 0, 0, 0);
    void'(txt.pop_back());
    send_text();
    make_stamp(1, 1, 2000, 0, 0, 0);
    repeat (3) txt.push_back(CHAR_ZERO);
    send_text();
    // position counter saturates well before the end of this one
    make_stamp(1, 1, 2000, 0, 0, 0);
    repeat (12) txt.push_back(CHAR_NINE);
    send_text();
    wait_drain();
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct, input int n);
    int stop_at;
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    stop_at = chars_sent + n;
    while (chars_sent < stop_at) send_random_string();
    wait_drain();
  endtask

  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req = 200;
    @(posedge clk);
    for (int i = 0; i < 14; i++) begin
      if (i % 2 == 0) begin
        make_plausible();
      end else begin
        txt.delete();
        repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(255)));
      end
      send_text();
    end
    wait_drain();
  endtask

  initial begin
    clear_parse();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle_pct = 35;
    out_stall_pct = 76;
    test_valid_strings();
    test_date_errors();
    test_time_errors();
    test_format_errors();
    test_length_errors();
    test_random_traffic(35, 76, 200);
    test_random_traffic(76, 35, 200);
    test_random_traffic(0, 0, 200);
    test_backpressure();
    $display("%0d strings in %0d characters, %0d results: %0d clean, %0d format, %0d date, %0d time",
             strings_sent, chars_sent, results_seen, err_seen[ERR_NONE],
             err_seen[ERR_FORMAT], err_seen[ERR_DATE], err_seen[ERR_TIME]);
    $display("input held off %0d cycles; %0d mismatches in %0d cycles",
             input_held, mismatches, cycle_cnt);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("** date_time_string_checker_top: PASSED **");
    end else begin
      $display("** date_time_string_checker_top: FAILED **");
    end
    $finish;
  end

endmodule
